// ===== rtl/mce_pkg.sv =====
// shared constants for the multipath channel emulator
package mce_pkg;

  localparam int DEF_MAX_TAPS = 16;
  localparam int DEF_MAX_TX   = 4;
  localparam int DEF_MAX_RX   = 4;

  localparam int SAMP_W = 16;
  localparam int ACC_W  = 48;
  localparam int CFG_W  = 16;
  localparam int CFG_AW = 3;
  localparam int CNT_W  = 7;

  localparam logic [CFG_AW-1:0] REG_TAP_COUNT = 3'd0;
  localparam logic [CFG_AW-1:0] REG_TX_COUNT  = 3'd1;
  localparam logic [CFG_AW-1:0] REG_RX_COUNT  = 3'd2;
  localparam logic [CFG_AW-1:0] REG_RX_ANT    = 3'd3;
  localparam logic [CFG_AW-1:0] REG_GAIN      = 3'd4;
  localparam logic [CFG_AW-1:0] REG_NSCALE    = 3'd5;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TAP    = 1'b1;

endpackage

// ===== rtl/mce_ram.sv =====
// generic single write port ram with registered read
module mce_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/mce_mac.sv =====
// complex multiply-accumulate unit, one tap per cycle
module mce_mac (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                clr,
  input  logic signed [mce_pkg::SAMP_W-1:0]   xr,
  input  logic signed [mce_pkg::SAMP_W-1:0]   xi,
  input  logic signed [mce_pkg::SAMP_W-1:0]   hr,
  input  logic signed [mce_pkg::SAMP_W-1:0]   hi,
  output logic                                busy,
  output logic signed [mce_pkg::ACC_W-1:0]    sum_re,
  output logic signed [mce_pkg::ACC_W-1:0]    sum_im
);

  logic signed [2*mce_pkg::SAMP_W-1:0] p_rr_r, p_ii_r, p_ir_r, p_ri_r;
  logic                                p_v_r;
  logic signed [mce_pkg::ACC_W-1:0]    sum_re_r, sum_im_r;

  // product stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else begin
      p_v_r <= en;
    end
    p_rr_r <= xr * hr;
    p_ii_r <= xi * hi;
    p_ir_r <= xi * hr;
    p_ri_r <= xr * hi;
  end

  // accumulate stage
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      sum_re_r <= '0;
      sum_im_r <= '0;
    end else if (p_v_r) begin
      sum_re_r <= sum_re_r + mce_pkg::ACC_W'(p_rr_r) - mce_pkg::ACC_W'(p_ii_r);
      sum_im_r <= sum_im_r + mce_pkg::ACC_W'(p_ir_r) + mce_pkg::ACC_W'(p_ri_r);
    end
  end

  assign busy   = p_v_r;
  assign sum_re = sum_re_r;
  assign sum_im = sum_im_r;

endmodule

// ===== rtl/mce_fin.sv =====
// gain, noise, rounding, prior addition and saturation for one part, on one shared multiplier
module mce_fin (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [mce_pkg::ACC_W-1:0]   acc,
  input  logic signed [mce_pkg::SAMP_W-1:0]  noise,
  input  logic signed [mce_pkg::SAMP_W-1:0]  prior,
  input  logic [mce_pkg::CFG_W-1:0]          gain,
  input  logic [mce_pkg::CFG_W-1:0]          scale,
  output logic                               done,
  output logic signed [mce_pkg::SAMP_W-1:0]  res,
  output logic                               clip
);

  localparam int MW = 25;
  localparam int PW = MW + mce_pkg::CFG_W + 1;
  localparam int VW = 66;
  localparam int RW = 42;
  localparam int TW = 43;

  typedef enum logic [6:0] {
    P_IDLE = 7'b0000001,
    P_LO   = 7'b0000010,
    P_HI   = 7'b0000100,
    P_NZ   = 7'b0001000,
    P_ADD  = 7'b0010000,
    P_RND  = 7'b0100000,
    P_SAT  = 7'b1000000
  } ph_t;

  ph_t                   ph_r, ph_nxt;
  logic signed [MW-1:0]  ma;
  logic signed [mce_pkg::CFG_W:0] mb;
  logic signed [PW-1:0]  prod_r;
  logic signed [VW-1:0]  v_r;
  logic        [VW-1:0]  mag;
  logic        [VW-1:0]  rsum;
  logic        [RW-1:0]  rmag;
  logic signed [RW-1:0]  rr_r;
  logic signed [TW-1:0]  t;
  logic signed [mce_pkg::SAMP_W-1:0] res_r;
  logic                  clip_r, done_r;

  // operand select for the shared multiplier
  always_comb begin
    case (ph_r)
      P_LO:    ma = $signed({1'b0, acc[23:0]});
      P_HI:    ma = $signed({acc[mce_pkg::ACC_W-1], acc[mce_pkg::ACC_W-1:24]});
      P_NZ:    ma = MW'(noise);
      default: ma = '0;
    endcase
    mb = (ph_r == P_NZ) ? $signed({1'b0, scale}) : $signed({1'b0, gain});
  end

  always_comb begin
    case (ph_r)
      P_IDLE:  ph_nxt = start ? P_LO : P_IDLE;
      P_LO:    ph_nxt = P_HI;
      P_HI:    ph_nxt = P_NZ;
      P_NZ:    ph_nxt = P_ADD;
      P_ADD:   ph_nxt = P_RND;
      P_RND:   ph_nxt = P_SAT;
      P_SAT:   ph_nxt = P_IDLE;
      default: ph_nxt = P_IDLE;
    endcase
  end

  // round half away from zero
  assign mag  = v_r[VW-1] ? VW'(-v_r) : VW'(v_r);
  assign rsum = mag + (VW'(1) << 26 - 1);
  assign rmag = RW'(rsum >> 26);
  assign t    = TW'(rr_r) + TW'(prior);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= P_IDLE;
      done_r <= 1'b0;
    end else begin
      ph_r   <= ph_nxt;
      done_r <= (ph_r == P_SAT);
    end
    prod_r <= ma * mb;
    case (ph_r)
      P_LO:  v_r <= '0;
      P_HI:  v_r <= v_r + VW'(prod_r);
      P_NZ:  v_r <= v_r + (VW'(prod_r) <<< 24);
      P_ADD: v_r <= v_r + (VW'(prod_r) <<< 6);
      default: v_r <= v_r;
    endcase
    if (ph_r == P_RND) begin
      rr_r <= v_r[VW-1] ? -$signed(rmag) : $signed(rmag);
    end
    if (ph_r == P_SAT) begin
      if (t > TW'(32767)) begin
        res_r  <= 16'sh7fff;
        clip_r <= 1'b1;
      end else if (t < -TW'(32768)) begin
        res_r  <= -16'sh8000;
        clip_r <= 1'b1;
      end else begin
        res_r  <= mce_pkg::SAMP_W'(t);
        clip_r <= 1'b0;
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;
  assign clip = clip_r;

endmodule

// ===== rtl/multipath_channel_emulator.sv =====
// multipath channel emulator: per-antenna delay lines, tap table, fir and output stage
// tap load: accepted while idle, no word out, ready stays high
// transmit word: tap reads, ram read, product and accumulate before the next word is accepted
// with no taps in use or the path outside the table a transmit word issues no tap reads
// last antenna of a step adds gain/noise/round/saturate on the shared multiplier
// synchronous active-low reset sets config to defaults, clears delay lines (valid bits) and sums
module multipath_channel_emulator #(
  parameter int MAX_TAPS = mce_pkg::DEF_MAX_TAPS,
  parameter int MAX_TX   = mce_pkg::DEF_MAX_TX,
  parameter int MAX_RX   = mce_pkg::DEF_MAX_RX
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_we,
  input  logic [mce_pkg::CFG_AW-1:0]        cfg_addr,
  input  logic [mce_pkg::CFG_W-1:0]         cfg_wdata,
  // input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_cmd,
  input  logic [3:0]                        in_path_index,
  input  logic [3:0]                        in_tap_index,
  input  logic signed [15:0]                in_tap_re,
  input  logic signed [15:0]                in_tap_im,
  input  logic signed [15:0]                in_sample_re,
  input  logic signed [15:0]                in_sample_im,
  input  logic signed [15:0]                in_prior_re,
  input  logic signed [15:0]                in_prior_im,
  input  logic signed [15:0]                in_noise_re,
  input  logic signed [15:0]                in_noise_im,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [15:0]                out_re,
  output logic signed [15:0]                out_im,
  output logic                              out_clipped
);

  localparam int NP  = MAX_TX * MAX_RX;
  localparam int HD  = MAX_TX * MAX_TAPS;
  localparam int TD  = NP * MAX_TAPS;
  localparam int HAW = (HD > 1) ? $clog2(HD) : 1;
  localparam int TAW = (TD > 1) ? $clog2(TD) : 1;
  localparam int SW  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int AW  = (MAX_TX > 1) ? $clog2(MAX_TX) : 1;
  localparam int CW  = mce_pkg::CNT_W;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_RUN    = 7'b0000010,
    S_FRE_GO = 7'b0000100,
    S_FRE_W  = 7'b0001000,
    S_FIM_GO = 7'b0010000,
    S_FIM_W  = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // config registers
  logic [4:0]  tap_count_r;
  logic [2:0]  tx_count_r, rx_count_r;
  logic [1:0]  rx_ant_r;
  logic [15:0] gain_r, scale_r;

  // step bookkeeping
  logic [AW-1:0] pos_r;
  logic [SW-1:0] ptr_r [MAX_TX];
  logic [HD-1:0] hv_r;

  // per-item working registers
  logic [HAW-1:0] hbase_r;
  logic [TAW-1:0] tbase_r;
  logic [SW-1:0]  rd_slot_r;
  logic [CW-1:0]  cnt_r, taps_r;
  logic           path_ok_r, last_r;
  logic signed [15:0] noise_re_r, noise_im_r, prior_re_r, prior_im_r;

  // read pipeline
  logic rd_v_r, hv_rd_r;

  // results
  logic signed [15:0] res_re_r;
  logic               clip_re_r;
  logic               out_valid_r, out_clip_r;
  logic signed [15:0] out_re_r, out_im_r;

  // derived
  logic           in_acc, smp_acc, tap_acc, tap_ok;
  logic [3:0]     txn, rxn;
  logic [CW-1:0]  taps;
  logic [6:0]     path;
  logic           last;
  logic [SW-1:0]  new_slot;
  logic [HAW-1:0] hist_waddr, hist_raddr;
  logic [TAW-1:0] tap_waddr, tap_raddr;
  logic [31:0]    hist_q, tap_q;
  logic           iss, run_done, out_free, fin_im;
  logic           mac_busy, mac_clr;
  logic signed [mce_pkg::ACC_W-1:0] sum_re, sum_im;
  logic           fin_start, fin_done, fin_clip;
  logic signed [15:0] fin_res;
  logic signed [15:0] xr, xi;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign smp_acc  = in_acc && (in_cmd == mce_pkg::CMD_SAMPLE);
  assign tap_acc  = in_acc && (in_cmd == mce_pkg::CMD_TAP);

  // antenna counts: zero acts as one, large values saturate
  assign txn = (tx_count_r == 3'd0) ? 4'd1 :
               ({1'b0, tx_count_r} > 4'(MAX_TX)) ? 4'(MAX_TX) : {1'b0, tx_count_r};
  assign rxn = (rx_count_r == 3'd0) ? 4'd1 :
               ({1'b0, rx_count_r} > 4'(MAX_RX)) ? 4'(MAX_RX) : {1'b0, rx_count_r};
  assign taps = (CW'(tap_count_r) > CW'(MAX_TAPS)) ? CW'(MAX_TAPS) : CW'(tap_count_r);

  assign path     = 7'(rx_ant_r) + 7'(32'(pos_r) * 32'(rxn));
  assign last     = (5'(pos_r) + 5'd1) >= 5'(txn);
  assign new_slot = (32'(ptr_r[pos_r]) == MAX_TAPS - 1) ? '0 : SW'(ptr_r[pos_r] + 1'b1);

  // delay line storage: circular buffer per antenna, newest at the pointer
  assign hist_waddr = HAW'(32'(pos_r) * MAX_TAPS + 32'(new_slot));
  assign hist_raddr = HAW'(hbase_r + HAW'(rd_slot_r));

  // tap table address: path row, tap column
  assign tap_ok    = (7'(in_path_index) < 7'(NP)) && (7'(in_tap_index) < 7'(MAX_TAPS));
  assign tap_waddr = TAW'(32'(in_path_index) * MAX_TAPS + 32'(in_tap_index));
  assign tap_raddr = TAW'(tbase_r + TAW'(cnt_r));

  mce_ram #(.WIDTH(32), .DEPTH(HD)) u_hist (
    .clk   (clk),
    .we    (smp_acc),
    .waddr (hist_waddr),
    .wdata ({in_sample_re, in_sample_im}),
    .raddr (hist_raddr),
    .rdata (hist_q)
  );

  mce_ram #(.WIDTH(32), .DEPTH(TD)) u_taps (
    .clk   (clk),
    .we    (tap_acc && tap_ok),
    .waddr (tap_waddr),
    .wdata ({in_tap_re, in_tap_im}),
    .raddr (tap_raddr),
    .rdata (tap_q)
  );

  // issue one tap read per cycle while taps remain
  assign iss      = (state_r == S_RUN) && path_ok_r && (cnt_r < taps_r);
  assign run_done = (state_r == S_RUN) && !iss && !rd_v_r && !mac_busy;

  // never-written history slots read as zero
  assign xr = hv_rd_r ? $signed(hist_q[31:16]) : 16'sd0;
  assign xi = hv_rd_r ? $signed(hist_q[15:0])  : 16'sd0;

  mce_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (rd_v_r),
    .clr    (mac_clr),
    .xr     (xr),
    .xi     (xi),
    .hr     ($signed(tap_q[31:16])),
    .hi     ($signed(tap_q[15:0])),
    .busy   (mac_busy),
    .sum_re (sum_re),
    .sum_im (sum_im)
  );

  // shared finishing unit, real part first then imaginary
  assign fin_im    = (state_r == S_FIM_GO) || (state_r == S_FIM_W);
  assign fin_start = (state_r == S_FRE_GO) || (state_r == S_FIM_GO);

  mce_fin u_fin (
    .clk   (clk),
    .rst_n (rst_n),
    .start (fin_start),
    .acc   (fin_im ? sum_im : sum_re),
    .noise (fin_im ? noise_im_r : noise_re_r),
    .prior (fin_im ? prior_im_r : prior_re_r),
    .gain  (gain_r),
    .scale (scale_r),
    .done  (fin_done),
    .res   (fin_res),
    .clip  (fin_clip)
  );

  assign out_free = !out_valid_r || out_ready;
  assign mac_clr  = (state_r == S_OUT) && out_free;

  always_comb begin
    case (state_r)
      S_IDLE:   state_nxt = smp_acc ? S_RUN : S_IDLE;
      S_RUN:    state_nxt = run_done ? (last_r ? S_FRE_GO : S_IDLE) : S_RUN;
      S_FRE_GO: state_nxt = S_FRE_W;
      S_FRE_W:  state_nxt = fin_done ? S_FIM_GO : S_FRE_W;
      S_FIM_GO: state_nxt = S_FIM_W;
      S_FIM_W:  state_nxt = fin_done ? S_OUT : S_FIM_W;
      S_OUT:    state_nxt = out_free ? S_IDLE : S_OUT;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tap_count_r <= 5'd16;
      tx_count_r  <= 3'd1;
      rx_count_r  <= 3'd1;
      rx_ant_r    <= 2'd0;
      gain_r      <= 16'd4096;
      scale_r     <= 16'd0;
      pos_r       <= '0;
      hv_r        <= '0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_TX; i++) begin
        ptr_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= iss;
      if (cfg_we) begin
        case (cfg_addr)
          mce_pkg::REG_TAP_COUNT: tap_count_r <= cfg_wdata[4:0];
          mce_pkg::REG_TX_COUNT:  tx_count_r  <= cfg_wdata[2:0];
          mce_pkg::REG_RX_COUNT:  rx_count_r  <= cfg_wdata[2:0];
          mce_pkg::REG_RX_ANT:    rx_ant_r    <= cfg_wdata[1:0];
          mce_pkg::REG_GAIN:      gain_r      <= cfg_wdata;
          mce_pkg::REG_NSCALE:    scale_r     <= cfg_wdata;
          default: ;
        endcase
      end
      if (smp_acc) begin
        ptr_r[pos_r]     <= new_slot;
        hv_r[hist_waddr] <= 1'b1;
        // antenna position wraps at the last antenna of the step
        pos_r <= last ? '0 : AW'(pos_r + 1'b1);
      end
      if (mac_clr) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (smp_acc) begin
      hbase_r    <= HAW'(32'(pos_r) * MAX_TAPS);
      tbase_r    <= TAW'(32'(path) * MAX_TAPS);
      path_ok_r  <= path < 7'(NP);
      taps_r     <= taps;
      last_r     <= last;
      rd_slot_r  <= new_slot;
      cnt_r      <= '0;
      noise_re_r <= in_noise_re;
      noise_im_r <= in_noise_im;
      prior_re_r <= in_prior_re;
      prior_im_r <= in_prior_im;
    end else if (iss) begin
      cnt_r     <= cnt_r + 1'b1;
      rd_slot_r <= (rd_slot_r == '0) ? SW'(MAX_TAPS - 1) : SW'(rd_slot_r - 1'b1);
    end
    hv_rd_r <= hv_r[hist_raddr];
    if ((state_r == S_FRE_W) && fin_done) begin
      res_re_r  <= fin_res;
      clip_re_r <= fin_clip;
    end
    if (mac_clr) begin
      out_re_r   <= res_re_r;
      out_im_r   <= fin_res;
      out_clip_r <= clip_re_r | fin_clip;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_re      = out_re_r;
  assign out_im      = out_im_r;
  assign out_clipped = out_clip_r;

endmodule

// ===== test/multipath_channel_emulator_check.sv =====
// checker for the multipath channel emulator: predicts output words and compares them
`timescale 1ns / 1ps
module multipath_channel_emulator_check (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_addr,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               in_cmd,
  input  logic [3:0]         in_path_index,
  input  logic [3:0]         in_tap_index,
  input  logic signed [15:0] in_tap_re,
  input  logic signed [15:0] in_tap_im,
  input  logic signed [15:0] in_sample_re,
  input  logic signed [15:0] in_sample_im,
  input  logic signed [15:0] in_prior_re,
  input  logic signed [15:0] in_prior_im,
  input  logic signed [15:0] in_noise_re,
  input  logic signed [15:0] in_noise_im,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] out_re,
  input  logic signed [15:0] out_im,
  input  logic               out_clipped,
  output int                 fail_count,
  output int                 pending_words
);

  typedef struct packed {
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic               clipped;
  } rx_word_t;

  logic [4:0]  tap_count_q;
  logic [2:0]  tx_count_q, rx_count_q;
  logic [1:0]  rx_ant_q;
  logic [15:0] gain_q, nscale_q;

  logic signed [15:0] hist_re [4][16];
  logic signed [15:0] hist_im [4][16];
  logic signed [15:0] coef_re [16][16];
  logic signed [15:0] coef_im [16][16];
  int unsigned        ant_pos;
  longint             acc_re, acc_im;
  rx_word_t           rx_expected [$];

  assign pending_words = rx_expected.size();

  // gain, noise, round half away from zero, add prior, saturate
  function automatic logic signed [15:0] scale_round_sat(longint acc, longint noise,
                                                         longint prior, inout logic clip);
    longint v, mag, r, t;
    v   = acc * longint'(gain_q) + noise * longint'(nscale_q) * 64;
    mag = v < 0 ? -v : v;
    r   = (mag + (longint'(1) << 25)) / (longint'(1) << 26);
    t   = (v < 0 ? -r : r) + prior;
    if (t > 32767) begin
      clip = 1'b1;
      return 16'sh7fff;
    end
    if (t < -32768) begin
      clip = 1'b1;
      return -16'sh8000;
    end
    return t[15:0];
  endfunction

  task automatic predict_word();
    int unsigned txn, rxn, taps, a, path;
    rx_word_t    w;
    logic        clip;
    if (in_cmd == mce_pkg::CMD_TAP) begin
      coef_re[in_path_index][in_tap_index] = in_tap_re;
      coef_im[in_path_index][in_tap_index] = in_tap_im;
      return;
    end
    txn  = tx_count_q == 0 ? 1 : (tx_count_q > 4 ? 4 : tx_count_q);
    rxn  = rx_count_q == 0 ? 1 : (rx_count_q > 4 ? 4 : rx_count_q);
    taps = tap_count_q > 16 ? 16 : tap_count_q;
    a    = ant_pos < 4 ? ant_pos : 3;
    for (int l = 15; l > 0; l--) begin
      hist_re[a][l] = hist_re[a][l-1];
      hist_im[a][l] = hist_im[a][l-1];
    end
    hist_re[a][0] = in_sample_re;
    hist_im[a][0] = in_sample_im;
    path = rx_ant_q + a * rxn;
    if (path < 16) begin
      for (int l = 0; l < taps; l++) begin
        acc_re += longint'(hist_re[a][l]) * coef_re[path][l]
                - longint'(hist_im[a][l]) * coef_im[path][l];
        acc_im += longint'(hist_im[a][l]) * coef_re[path][l]
                + longint'(hist_re[a][l]) * coef_im[path][l];
      end
    end
    if (a + 1 < txn) begin
      ant_pos = a + 1;
      return;
    end
    clip = 1'b0;
    w.re = scale_round_sat(acc_re, in_noise_re, in_prior_re, clip);
    w.im = scale_round_sat(acc_im, in_noise_im, in_prior_im, clip);
    w.clipped = clip;
    rx_expected.push_back(w);
    ant_pos = 0;
    acc_re  = 0;
    acc_im  = 0;
  endtask

  always @(posedge clk) begin
    rx_word_t e;
    if (!rst_n) begin
      tap_count_q = 5'd16;
      tx_count_q  = 3'd1;
      rx_count_q  = 3'd1;
      rx_ant_q    = 2'd0;
      gain_q      = 16'd4096;
      nscale_q    = 16'd0;
      ant_pos     = 0;
      acc_re      = 0;
      acc_im      = 0;
      fail_count  = 0;
      rx_expected.delete();
      for (int p = 0; p < 4; p++)
        for (int l = 0; l < 16; l++) begin
          hist_re[p][l] = 16'sd0;
          hist_im[p][l] = 16'sd0;
        end
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          mce_pkg::REG_TAP_COUNT: tap_count_q = cfg_wdata[4:0];
          mce_pkg::REG_TX_COUNT:  tx_count_q  = cfg_wdata[2:0];
          mce_pkg::REG_RX_COUNT:  rx_count_q  = cfg_wdata[2:0];
          mce_pkg::REG_RX_ANT:    rx_ant_q    = cfg_wdata[1:0];
          mce_pkg::REG_GAIN:      gain_q      = cfg_wdata;
          mce_pkg::REG_NSCALE:    nscale_q    = cfg_wdata;
          default: ;
        endcase
      end
      // output side first: a word cannot leave in the cycle its item enters
      if (out_valid && out_ready) begin
        if (rx_expected.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected word re=%0d im=%0d clip=%0b", out_re, out_im, out_clipped);
        end else begin
          e = rx_expected.pop_front();
          if (out_re !== e.re || out_im !== e.im || out_clipped !== e.clipped) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected re=%0d im=%0d clip=%0b, got re=%0d im=%0d clip=%0b",
                       e.re, e.im, e.clipped, out_re, out_im, out_clipped);
          end
        end
      end
      if (in_valid && in_ready) predict_word();
    end
  end
endmodule

// ===== test/multipath_channel_emulator_test.sv =====
// testbench top for the multipath channel emulator: stimulus, config phases, verdict
`timescale 1ns / 1ps
module multipath_channel_emulator_test;

  localparam int IDLE_LIMIT = 20000;  // cycles with no handshake before giving up

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_cmd = mce_pkg::CMD_SAMPLE;
  logic [3:0] in_path_index = '0, in_tap_index = '0;
  logic signed [15:0] in_tap_re = '0, in_tap_im = '0;
  logic signed [15:0] in_sample_re = '0, in_sample_im = '0;
  logic signed [15:0] in_prior_re = '0, in_prior_im = '0;
  logic signed [15:0] in_noise_re = '0, in_noise_im = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_re, out_im;
  logic out_clipped;
  int fail_count, pending_words;
  int idle_cycles = 0;
  int stall_left = 0;
  bit stim_done = 1'b0;

  always #1 clk = ~clk;

  multipath_channel_emulator i_dut (
    .clk, .rst_n, .cfg_we, .cfg_addr, .cfg_wdata,
    .in_valid, .in_ready, .in_cmd, .in_path_index, .in_tap_index,
    .in_tap_re, .in_tap_im, .in_sample_re, .in_sample_im,
    .in_prior_re, .in_prior_im, .in_noise_re, .in_noise_im,
    .out_valid, .out_ready, .out_re, .out_im, .out_clipped
  );

  multipath_channel_emulator_check i_check (
    .clk, .rst_n, .cfg_we, .cfg_addr, .cfg_wdata,
    .in_valid, .in_ready, .in_cmd, .in_path_index, .in_tap_index,
    .in_tap_re, .in_tap_im, .in_sample_re, .in_sample_im,
    .in_prior_re, .in_prior_im, .in_noise_re, .in_noise_im,
    .out_valid, .out_ready, .out_re, .out_im, .out_clipped,
    .fail_count, .pending_words
  );

  // mostly short gaps, now and then a long one, sometimes none at all
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // result side: short random stalls, now and then a long one, changed at the falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= stim_done;
      end else if ($urandom_range(0, 99) < 2) begin
        stall_left <= $urandom_range(10, 60);
        out_ready  <= stim_done;
      end else begin
        out_ready <= ($urandom_range(0, 99) < 70) || stim_done;
      end
    end
  end

  // watchdog: no handshake on either channel for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // present one word, hold it until accepted, then a random gap
  task automatic send_word(input logic cmd, input logic [3:0] pidx, input logic [3:0] tidx,
                           input logic [15:0] tre, input logic [15:0] tim,
                           input logic [15:0] sre, input logic [15:0] sim,
                           input logic [15:0] pre, input logic [15:0] pim,
                           input logic [15:0] nre, input logic [15:0] nim);
    int g;
    in_valid <= 1'b1;
    in_cmd <= cmd; in_path_index <= pidx; in_tap_index <= tidx;
    in_tap_re <= tre; in_tap_im <= tim;
    in_sample_re <= sre; in_sample_im <= sim;
    in_prior_re <= pre; in_prior_im <= pim;
    in_noise_re <= nre; in_noise_im <= nim;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  task automatic load_tap(input logic [3:0] p, input logic [3:0] t,
                          input logic [15:0] re, input logic [15:0] im);
    send_word(mce_pkg::CMD_TAP, p, t, re, im, 16'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic send_sample(input logic [15:0] sre, input logic [15:0] sim,
                             input logic [15:0] pre, input logic [15:0] pim,
                             input logic [15:0] nre, input logic [15:0] nim);
    send_word(mce_pkg::CMD_SAMPLE, 4'($urandom), 4'($urandom), 16'($urandom),
              16'($urandom), sre, sim, pre, pim, nre, nim);
  endtask

  // random sample word: mostly moderate values, sometimes full scale
  task automatic rand_sample();
    logic [15:0] v [6];
    for (int k = 0; k < 6; k++)
      v[k] = ($urandom_range(0, 3) == 0) ? 16'($urandom)
             : 16'($signed($urandom_range(0, 4000)) - 2000);
    send_sample(v[0], v[1], v[2], v[3], v[4], v[5]);
  endtask

  // hold off the sender until every expected word is out, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_words != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  initial begin
    int n;
    int unsigned taps, txn, rxn;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // fill the whole tap table so no read ever hits an unwritten tap
    for (int p = 0; p < 16; p++)
      for (int t = 0; t < 16; t++)
        load_tap(p[3:0], t[3:0], $urandom_range(0, 3) == 0 ? 16'($urandom)
                 : 16'($signed($urandom_range(0, 2048)) - 1024),
                 16'($urandom_range(0, 2048) - 1024));

    // directed: reset config, extreme samples and priors
    send_sample(16'h7fff, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_sample(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    send_sample(16'hffff, 16'h0001, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    // full-scale taps at the extremes
    load_tap(4'd0, 4'd0, 16'h7fff, 16'h8000);
    load_tap(4'd0, 4'd1, 16'h8000, 16'h7fff);
    send_sample(16'h7fff, 16'h7fff, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_sample(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h0000, 16'h0000);
    drain();
    // extreme gain and noise, zero taps in use
    write_reg(mce_pkg::REG_GAIN, 16'hffff);
    write_reg(mce_pkg::REG_NSCALE, 16'hffff);
    write_reg(mce_pkg::REG_TAP_COUNT, 16'd0);
    send_sample(16'h1234, 16'h4321, 16'h0000, 16'h0000, 16'h7fff, 16'h8000);
    send_sample(16'h0000, 16'h0000, 16'h0100, 16'hff00, 16'h0001, 16'hffff);
    drain();
    // out-of-range counts: tap count above max, zero antenna counts
    write_reg(mce_pkg::REG_TAP_COUNT, 16'd31);
    write_reg(mce_pkg::REG_TX_COUNT, 16'd0);
    write_reg(mce_pkg::REG_RX_COUNT, 16'd0);
    write_reg(mce_pkg::REG_NSCALE, 16'd0);
    write_reg(mce_pkg::REG_GAIN, 16'd0);
    send_sample(16'h0abc, 16'h0cba, 16'h0005, 16'hfffb, 16'h0000, 16'h0000);
    drain();
    // antenna counts above max saturate, receive antenna 3: every path stays inside the table
    write_reg(mce_pkg::REG_GAIN, 16'd4096);
    write_reg(mce_pkg::REG_TX_COUNT, 16'd7);
    write_reg(mce_pkg::REG_RX_COUNT, 16'd7);
    write_reg(mce_pkg::REG_RX_ANT, 16'd3);
    repeat (8) rand_sample();
    drain();
    // lower tx_count mid-step: the next sample completes the step
    write_reg(mce_pkg::REG_TX_COUNT, 16'd4);
    write_reg(mce_pkg::REG_RX_COUNT, 16'd4);
    repeat (3) rand_sample();
    drain();
    write_reg(mce_pkg::REG_TX_COUNT, 16'd2);
    rand_sample();
    drain();

    // random phases
    for (int ph = 0; ph < 12; ph++) begin
      taps = (ph == 0) ? 16 : (ph == 1 ? 1 : $urandom_range(0, 31));
      txn  = (ph == 0) ? 4 : (ph == 1 ? 1 : $urandom_range(0, 7));
      rxn  = (ph == 0) ? 4 : (ph == 1 ? 1 : $urandom_range(0, 7));
      write_reg(mce_pkg::REG_TAP_COUNT, 16'(taps));
      write_reg(mce_pkg::REG_TX_COUNT, 16'(txn));
      write_reg(mce_pkg::REG_RX_COUNT, 16'(rxn));
      write_reg(mce_pkg::REG_RX_ANT, 16'($urandom_range(0, 3)));
      write_reg(mce_pkg::REG_GAIN, ph == 0 ? 16'hffff : 16'($urandom_range(0, 8192)));
      write_reg(mce_pkg::REG_NSCALE, ph == 1 ? 16'hffff : 16'($urandom_range(0, 512)));
      n = 0;
      while (n < 145) begin
        if ($urandom_range(0, 15) == 0)
          load_tap(4'($urandom), 4'($urandom), 16'($urandom), 16'($urandom));
        else
          rand_sample();
        n++;
      end
      drain();
    end

    stim_done = 1'b1;
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
